>>> rtl/core/cvv_pkg.sv
// shared types and constants for the cylindrical vortex velocity update pipeline
// no dependencies; imported by cvv_isqrt, cvv_div and the top level
`default_nettype none

package cvv_pkg;

    // pipelined square root: one result bit per stage
    localparam int unsigned SQ_STEPS  = 31;
    // pipelined divider: one quotient bit per stage
    localparam int unsigned DIV_STEPS = 32;
    // register stages from accepted beat to result strobe
    localparam int unsigned PIPE_LAT  = 77;

    // on-axis threshold: (7 lsb of q16.16 in q.30)^2
    localparam logic [61:0] EPS_SQ = 62'(49) << 28;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_AXIS_X   = 3'd3,
        CFG_AXIS_Y   = 3'd4,
        CFG_AXIS_Z   = 3'd5,
        CFG_STRENGTH = 3'd6,
        CFG_ROTATION = 3'd7
    } t_cfg_idx;

    // data riding along the square root
    typedef struct packed {
        logic [2:0][29:0] ms;
        logic [2:0]       vneg;
        logic             on_axis;
        logic [2:0][31:0] vel;
    } t_sq_side;

    // data riding along the divider and the back end
    typedef struct packed {
        logic [2:0]       vneg;
        logic             on_axis;
        logic [2:0][31:0] vel;
    } t_div_side;

endpackage

`default_nettype wire

>>> rtl/core/cvv_isqrt.sv
// pipelined integer square root, floor(sqrt(x)) of a 62-bit value
// depends on cvv_pkg (stage count, sideband type)
`default_nettype none

module cvv_isqrt import cvv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [61:0] i_val,
    input  t_sq_side    i_side,
    output logic        o_vld,
    output logic [30:0] o_root,
    output t_sq_side    o_side
);

    logic [SQ_STEPS-1:0] r_vld;
    logic [62:0]         r_n   [SQ_STEPS];
    logic [62:0]         r_res [SQ_STEPS];
    t_sq_side            r_side[SQ_STEPS];

    // one digit of the classic bit-pair square root
    function automatic logic [125:0] sq_step(input logic [62:0] n, input logic [62:0] res,
                                             input int unsigned j);
        logic [62:0] bitv;
        logic [62:0] trial;
        logic [62:0] n_o;
        logic [62:0] r_o;
        bitv  = 63'(1) << (2 * (SQ_STEPS - 1 - j));
        trial = res + bitv;
        if (n >= trial) begin
            n_o = n - trial;
            r_o = (res >> 1) + bitv;
        end else begin
            n_o = n;
            r_o = res >> 1;
        end
        return {n_o, r_o};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQ_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        {r_n[0], r_res[0]} <= sq_step({1'b0, i_val}, 63'(0), 0);
        r_side[0]          <= i_side;
        for (int j = 1; j < SQ_STEPS; j++) begin
            {r_n[j], r_res[j]} <= sq_step(r_n[j-1], r_res[j-1], j);
            r_side[j]          <= r_side[j-1];
        end
    end

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_root = r_res[SQ_STEPS-1][30:0];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/cvv_div.sv
// pipelined restoring divider, three 62-bit numerators over one 31-bit divisor
// depends on cvv_pkg (stage count, sideband type)
`default_nettype none

module cvv_div import cvv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [2:0][61:0] i_num,
    input  logic [30:0]      i_den,
    input  t_div_side        i_side,
    output logic             o_vld,
    output logic [2:0][31:0] o_quo,
    output t_div_side        o_side
);

    logic [DIV_STEPS-1:0] r_vld;
    logic [2:0][61:0]     r_rem [DIV_STEPS];
    logic [2:0][31:0]     r_quo [DIV_STEPS];
    logic [30:0]          r_den [DIV_STEPS];
    t_div_side            r_side[DIV_STEPS];

    // one quotient bit, msb first
    function automatic logic [93:0] div_step(input logic [61:0] rem, input logic [31:0] quo,
                                             input logic [30:0] den, input int unsigned j);
        logic [62:0] sub;
        logic [61:0] rem_o;
        logic [31:0] quo_o;
        sub   = 63'(den) << (DIV_STEPS - 1 - j);
        rem_o = rem;
        quo_o = quo;
        if ({1'b0, rem} >= sub) begin
            rem_o = 62'({1'b0, rem} - sub);
            quo_o[DIV_STEPS-1-j] = 1'b1;
        end
        return {rem_o, quo_o};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            {r_rem[0][l], r_quo[0][l]} <= div_step(i_num[l], 32'(0), i_den, 0);
        end
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int j = 1; j < DIV_STEPS; j++) begin
            for (int l = 0; l < 3; l++) begin
                {r_rem[j][l], r_quo[j][l]} <=
                    div_step(r_rem[j-1][l], r_quo[j-1][l], r_den[j-1], j);
            end
            r_den[j]  <= r_den[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_quo  = r_quo[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/cylindrical_vortex_velocity_update.sv
// top level: cylindrical vortex velocity update, q16.16 particle stream
// depends on cvv_pkg, cvv_isqrt, cvv_div
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------------
//  input     | in        | start, busy          | i_pos_x/y/z, i_vel_x/y/z
//  result    | out       | o_valid (strobe)     | o_new_vel_x/y/z, o_on_axis
//  config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one beat accepted per cycle, busy is never raised
// each result follows its input beat through 6 front stages, 31 square
// root stages, 2 numerator stages, 32 divider stages, 6 back stages
// synchronous active-low reset clears the valid chain and the config registers
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module cylindrical_vortex_velocity_update import cvv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    output logic        o_valid,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic [31:0] o_new_vel_z,
    output logic        o_on_axis,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_origin_x, r_origin_y, r_origin_z;
    logic signed [15:0] r_axis_x, r_axis_y, r_axis_z;
    logic signed [31:0] r_strength;
    logic        [31:0] r_rotation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_axis_x   <= '0;
            r_axis_y   <= '0;
            r_axis_z   <= 16'sd16384;
            r_strength <= '0;
            r_rotation <= 32'd16384;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_origin_z <= i_cfg_data;
                CFG_AXIS_X:   r_axis_x   <= i_cfg_data[15:0];
                CFG_AXIS_Y:   r_axis_y   <= i_cfg_data[15:0];
                CFG_AXIS_Z:   r_axis_z   <= i_cfg_data[15:0];
                CFG_STRENGTH: r_strength <= i_cfg_data;
                CFG_ROTATION: r_rotation <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // change config only while idle (unenforced); every stage reads it directly
    logic signed [15:0] n_cos, n_sin;
    logic        [31:0] n_smag;
    assign n_cos  = r_rotation[15:0];
    assign n_sin  = r_rotation[31:16];
    assign n_smag = r_strength[31] ? 32'(-r_strength) : r_strength;

    assign busy = 1'b0;

    logic n_accept;
    assign n_accept = start & ~busy;

    // ---------------- front end ----------------
    logic [5:0]         r_fvld;
    logic signed [32:0] r_rel [3];
    logic signed [49:0] r_v   [3];
    logic        [48:0] r_m   [3];
    logic        [29:0] r_ms4 [3];
    logic        [29:0] r_ms5 [3];
    logic        [29:0] r_ms6 [3];
    logic        [59:0] r_sq  [3];
    logic               r_s0_4, r_s0_5;
    logic        [61:0] r_sum;
    t_div_side          r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [48:0] n_maxm;
    logic [4:0]  n_shift;
    logic [61:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
        end else begin
            r_fvld <= {r_fvld[4:0], n_accept};
        end
    end

    // largest magnitude and the right shift that brings it below 2^30
    always_comb begin
        n_maxm = r_m[0];
        if (r_m[1] > n_maxm) begin
            n_maxm = r_m[1];
        end
        if (r_m[2] > n_maxm) begin
            n_maxm = r_m[2];
        end
        n_shift = '0;
        for (int b = 0; b < 19; b++) begin
            if (n_maxm[30+b]) begin
                n_shift = 5'(b + 1);
            end
        end
    end

    assign n_sum = 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        // stage 1: offset from the origin, exact in 33 bits
        r_rel[0]   <= {i_pos_x[31], i_pos_x} - {r_origin_x[31], r_origin_x};
        r_rel[1]   <= {i_pos_y[31], i_pos_y} - {r_origin_y[31], r_origin_y};
        r_rel[2]   <= {i_pos_z[31], i_pos_z} - {r_origin_z[31], r_origin_z};
        r_c1.vel   <= {i_vel_z, i_vel_y, i_vel_x};
        r_c1.vneg  <= '0;
        r_c1.on_axis <= 1'b0;

        // stage 2: v = axis x rel, q.30
        r_v[0] <= 50'(r_axis_y) * 50'(r_rel[2]) - 50'(r_axis_z) * 50'(r_rel[1]);
        r_v[1] <= 50'(r_axis_z) * 50'(r_rel[0]) - 50'(r_axis_x) * 50'(r_rel[2]);
        r_v[2] <= 50'(r_axis_x) * 50'(r_rel[1]) - 50'(r_axis_y) * 50'(r_rel[0]);
        r_c2   <= r_c1;

        // stage 3: magnitudes and signs
        r_c3.vel     <= r_c2.vel;
        r_c3.on_axis <= r_c2.on_axis;
        for (int i = 0; i < 3; i++) begin
            r_m[i]       <= r_v[i][49] ? 49'(-r_v[i]) : 49'(r_v[i]);
            r_c3.vneg[i] <= r_v[i][49];
        end

        // stage 4: normalize so the squares fit
        for (int i = 0; i < 3; i++) begin
            r_ms4[i] <= 30'(r_m[i] >> n_shift);
        end
        r_s0_4 <= (n_shift == '0);
        r_c4   <= r_c3;

        // stage 5: squares
        for (int i = 0; i < 3; i++) begin
            r_sq[i]  <= 60'(r_ms4[i]) * 60'(r_ms4[i]);
            r_ms5[i] <= r_ms4[i];
        end
        r_s0_5 <= r_s0_4;
        r_c5   <= r_c4;

        // stage 6: sum of squares and the on-axis test on unshifted v
        r_sum <= n_sum;
        for (int i = 0; i < 3; i++) begin
            r_ms6[i] <= r_ms5[i];
        end
        r_c6.vel     <= r_c5.vel;
        r_c6.vneg    <= r_c5.vneg;
        r_c6.on_axis <= r_s0_5 && (n_sum < EPS_SQ);
    end

    // ---------------- length ----------------
    t_sq_side    n_sq_in;
    t_sq_side    n_sq_out;
    logic        n_sq_vld;
    logic [30:0] n_len;

    always_comb begin
        n_sq_in.vel     = r_c6.vel;
        n_sq_in.vneg    = r_c6.vneg;
        n_sq_in.on_axis = r_c6.on_axis;
        for (int i = 0; i < 3; i++) begin
            n_sq_in.ms[i] = r_ms6[i];
        end
    end

    cvv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fvld[5]),
        .i_val   (r_sum),
        .i_side  (n_sq_in),
        .o_vld   (n_sq_vld),
        .o_root  (n_len),
        .o_side  (n_sq_out)
    );

    // ---------------- numerator ----------------
    logic [1:0]       r_nvld;
    logic [61:0]      r_prod [3];
    logic [30:0]      r_len1, r_len2;
    logic [2:0][61:0] r_num;
    t_div_side        r_c7, r_c8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= '0;
        end else begin
            r_nvld <= {r_nvld[0], n_sq_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= 62'(n_sq_out.ms[i]) * 62'(n_smag);
        end
        r_len1       <= n_len;
        r_c7.vel     <= n_sq_out.vel;
        r_c7.vneg    <= n_sq_out.vneg;
        r_c7.on_axis <= n_sq_out.on_axis;

        // round to nearest: add half the divisor
        for (int i = 0; i < 3; i++) begin
            r_num[i] <= r_prod[i] + 62'(r_len1 >> 1);
        end
        r_len2 <= r_len1;
        r_c8   <= r_c7;
    end

    // ---------------- scale to strength ----------------
    logic             n_div_vld;
    logic [2:0][31:0] n_quo;
    t_div_side        n_div_side;

    cvv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_nvld[1]),
        .i_num   (r_num),
        .i_den   (r_len2),
        .i_side  (r_c8),
        .o_vld   (n_div_vld),
        .o_quo   (n_quo),
        .o_side  (n_div_side)
    );

    // ---------------- rotate and accumulate ----------------
    logic [5:0]         r_bvld;
    logic signed [32:0] r_t1 [3];
    logic signed [32:0] r_t2 [3];
    logic signed [32:0] r_t3 [3];
    logic signed [49:0] r_kd [3];
    logic signed [35:0] r_k  [3];
    logic signed [48:0] r_pc [3];
    logic signed [51:0] r_ps [3];
    logic signed [39:0] r_sv [3];
    t_div_side          r_d1, r_d2, r_d3, r_d4, r_d5;
    logic        [31:0] r_out [3];
    logic               r_out_axis;

    logic signed [52:0] n_rot [3];
    logic signed [38:0] n_w   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rot[i] = 53'(r_pc[i]) + 53'(r_ps[i]) + 53'sd8192;
            n_w[i]   = 39'(n_rot[i] >>> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
        end else begin
            r_bvld <= {r_bvld[4:0], n_div_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // signed scaled vector t, q16.16
        for (int i = 0; i < 3; i++) begin
            if (n_div_side.vneg[i] ^ r_strength[31]) begin
                r_t1[i] <= -$signed({1'b0, n_quo[i]});
            end else begin
                r_t1[i] <= $signed({1'b0, n_quo[i]});
            end
        end
        r_d1 <= n_div_side;

        // axis x t, q.30
        r_kd[0] <= 50'(r_axis_y) * 50'(r_t1[2]) - 50'(r_axis_z) * 50'(r_t1[1]);
        r_kd[1] <= 50'(r_axis_z) * 50'(r_t1[0]) - 50'(r_axis_x) * 50'(r_t1[2]);
        r_kd[2] <= 50'(r_axis_x) * 50'(r_t1[1]) - 50'(r_axis_y) * 50'(r_t1[0]);
        r_t2    <= r_t1;
        r_d2    <= r_d1;

        // round half up back to q16.16
        for (int i = 0; i < 3; i++) begin
            r_k[i] <= 36'((r_kd[i] + 50'sd8192) >>> 14);
        end
        r_t3 <= r_t2;
        r_d3 <= r_d2;

        // t*cos and k*sin
        for (int i = 0; i < 3; i++) begin
            r_pc[i] <= 49'(r_t3[i]) * 49'(n_cos);
            r_ps[i] <= 52'(r_k[i]) * 52'(n_sin);
        end
        r_d4 <= r_d3;

        // rounded rotation added to the velocity
        for (int i = 0; i < 3; i++) begin
            r_sv[i] <= 40'($signed(r_d4.vel[i])) + 40'(n_w[i]);
        end
        r_d5 <= r_d4;

        // saturate, or pass the velocity when on the axis
        for (int i = 0; i < 3; i++) begin
            if (r_d5.on_axis) begin
                r_out[i] <= r_d5.vel[i];
            end else if (r_sv[i] > 40'sd2147483647) begin
                r_out[i] <= 32'h7fff_ffff;
            end else if (r_sv[i] < -40'sd2147483648) begin
                r_out[i] <= 32'h8000_0000;
            end else begin
                r_out[i] <= r_sv[i][31:0];
            end
        end
        r_out_axis <= r_d5.on_axis;
    end

    assign o_valid     = r_bvld[5];
    assign o_new_vel_x = r_out[0];
    assign o_new_vel_y = r_out[1];
    assign o_new_vel_z = r_out[2];
    assign o_on_axis   = r_out_axis;

`ifndef SYNTH
    // every strobe traces back to an accepted beat at fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(n_accept, PIPE_LAT))
        else $error("result strobe without matching input beat");

    // on-axis results carry the original velocity
    a_on_axis_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_on_axis) |->
            (o_new_vel_x == $past(i_vel_x, PIPE_LAT)) &&
            (o_new_vel_y == $past(i_vel_y, PIPE_LAT)) &&
            (o_new_vel_z == $past(i_vel_z, PIPE_LAT)))
        else $error("on-axis result does not match input velocity");

    // reset flushes the whole pipe
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule

`default_nettype wire

>>> verif/tb_cylindrical_vortex_velocity_update.sv
// self-checking testbench for cylindrical_vortex_velocity_update
// depends on cvv_pkg and the top level; a bit-exact velocity predictor checks every result beat
`default_nettype none

module tb_cylindrical_vortex_velocity_update;
    import cvv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic [31:0] nv[3];
        logic        on_axis;
    } t_vel_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic        o_valid;
    logic [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic        o_on_axis;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_ORIGIN_X;
    logic [31:0] i_cfg_data = '0;

    cylindrical_vortex_velocity_update DUT (.*);

    always #4 i_clk = ~i_clk;

    // predictor copy of the register file, reset values
    longint             org[3] = '{0, 0, 0};
    logic signed [15:0] axv[3] = '{16'sd0, 16'sd0, 16'sd16384};
    logic [31:0]        strength_r = '0;
    logic [31:0]        rot_r = 32'd16384;

    t_vel_beat pending_vel[$];
    int        fails = 0;
    int        idle_cycles = 0;

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // expected velocity update for one particle under the current registers
    function automatic t_vel_beat predict_velocity(logic [31:0] p[3], logic [31:0] vin[3]);
        longint          rel[3], ax[3], v[3], t[3], k[3], w, sum_v, strn, cs, sn;
        longint unsigned m[3], mx, sum, len, smag, q;
        int              sh;
        t_vel_beat       res;
        for (int i = 0; i < 3; i++) begin
            rel[i] = longint'($signed(p[i])) - org[i];
            ax[i]  = longint'(axv[i]);
        end
        v[0] = ax[1] * rel[2] - ax[2] * rel[1];
        v[1] = ax[2] * rel[0] - ax[0] * rel[2];
        v[2] = ax[0] * rel[1] - ax[1] * rel[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            sum += m[i] * m[i];
        end
        if (sh == 0 && sum < 64'(EPS_SQ)) begin
            res.nv = vin;
            res.on_axis = 1'b1;
            return res;
        end
        len  = root_floor(sum);
        strn = longint'($signed(strength_r));
        smag = (strn < 0) ? -strn : strn;
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * smag + (len >> 1)) / len;
            t[i] = ((v[i] < 0) != (strn < 0)) ? -longint'(q) : longint'(q);
        end
        // round half up is a floor shift after adding half an lsb
        k[0] = (ax[1] * t[2] - ax[2] * t[1] + 8192) >>> 14;
        k[1] = (ax[2] * t[0] - ax[0] * t[2] + 8192) >>> 14;
        k[2] = (ax[0] * t[1] - ax[1] * t[0] + 8192) >>> 14;
        cs = longint'($signed(rot_r[15:0]));
        sn = longint'($signed(rot_r[31:16]));
        for (int i = 0; i < 3; i++) begin
            w = (t[i] * cs + k[i] * sn + 8192) >>> 14;
            sum_v = longint'($signed(vin[i])) + w;
            if (sum_v > 64'sd2147483647) sum_v = 64'sd2147483647;
            if (sum_v < -64'sd2147483648) sum_v = -64'sd2147483648;
            res.nv[i] = sum_v[31:0];
        end
        res.on_axis = 1'b0;
        return res;
    endfunction

    // register write, only issued while the pipeline is empty
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_ORIGIN_X: org[0] = longint'($signed(data));
            CFG_ORIGIN_Y: org[1] = longint'($signed(data));
            CFG_ORIGIN_Z: org[2] = longint'($signed(data));
            CFG_AXIS_X:   axv[0] = data[15:0];
            CFG_AXIS_Y:   axv[1] = data[15:0];
            CFG_AXIS_Z:   axv[2] = data[15:0];
            CFG_STRENGTH: strength_r = data;
            CFG_ROTATION: rot_r = data;
            default: ;
        endcase
    endtask

    // wait for every expected beat, then let the pipe run dry
    task automatic drain_pipe();
        while (pending_vel.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] axx, logic [31:0] axy, logic [31:0] axz,
                             logic [31:0] strn, logic [31:0] rot);
        drain_pipe();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_AXIS_X, axx);
        write_reg(CFG_AXIS_Y, axy);
        write_reg(CFG_AXIS_Z, axz);
        write_reg(CFG_STRENGTH, strn);
        write_reg(CFG_ROTATION, rot);
    endtask

    // one input beat: drive at the falling edge, hold until accepted
    task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                 logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        logic [31:0] p[3], vin[3];
        p   = '{px, py, pz};
        vin = '{vx, vy, vz};
        @(negedge i_clk);
        start = 1'b1;
        {i_pos_x, i_pos_y, i_pos_z} = {px, py, pz};
        {i_vel_x, i_vel_y, i_vel_z} = {vx, vy, vz};
        // busy only moves at a rising edge, so its value at the falling edge still holds there
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_vel.push_back(predict_velocity(p, vin));
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(99);
        if (r < 55) n = 0;
        else if (r < 90) n = $urandom_range(3, 1);
        else if (r < 98) n = $urandom_range(12, 4);
        else n = $urandom_range(150, 20);
        if (n != 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // signed value in [-2^k, 2^k]
    function automatic logic [31:0] small_offset(int k);
        longint span;
        span = longint'(1) << k;
        return 32'(longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    function automatic logic [31:0] rand_axis();
        return 32'($signed($urandom_range(32768)) - 16384);
    endfunction

    // reset register values, then the on-axis edge and the extremes
    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        send_particle(0, 0, 0, 1, 2, 3);
        send_particle(32'h0001_0000, 0, 0, mx, mn, 0);
        stop_sending();
        write_all(0, 0, 0, 0, 0, 16384, 32'h0004_0000, {16'sd11585, 16'sd11585});
        // on axis: along the axis, and just inside the epsilon radius
        send_particle(0, 0, mx, 5, 6, 7);
        send_particle(6, 0, mn, mx, mn, 1);
        send_particle(0, 32'hffff_fffa, 0, 0, 0, 0);
        // just outside the epsilon radius on two axes, and one more just inside it
        send_particle(7, 0, 0, 0, 0, 0);
        send_particle(0, 32'hffff_fff9, 0, 0, 0, 0);
        send_particle(4, 5, 0, 0, 0, 0);
        // saturation both ways
        send_particle(32'h0001_0000, 0, 0, mx, mx, mx);
        send_particle(32'hffff_0000, 0, 0, mn, mn, mn);
        send_particle(mx, mx, mx, mx, mn, mx);
        send_particle(mn, mn, mn, mn, mx, mn);
        stop_sending();
        // shifted magnitudes: relative position beyond the 32-bit range
        write_all(mn, mx, mn, 16384, 32'hffff_c000, 16384, mx, 32'hc000_c000);
        send_particle(mx, mn, mx, 0, 0, 0);
        send_particle(mn, mn, mn, mx, mx, mn);
        send_particle(mx, mx, mx, 0, mx, mn);
        send_particle(mx, mx, 0, 32'h1234_5678, 32'hedcb_a987, 0);
        stop_sending();
        write_all(mx, mn, mx, 32'hffff_c000, 16384, 32'hffff_c000, mn, 32'h4000_4000);
        send_particle(mn, mx, mn, 0, 0, 0);
        send_particle(0, 0, 0, mn, mn, mn);
        send_particle(mx, mx, mx, mx, mx, mx);
        send_particle(1, 2, 3, 4, 5, 6);
        stop_sending();
    endtask

    // random phases, each under fresh register values; one phase pauses until drained
    task automatic test_random_phases();
        logic [31:0] ox, oy, oz, ax, ay, az, st, rt, p[3], vin[3];
        int          sel, k;
        for (int ph = 0; ph < 8; ph++) begin
            ox = $urandom();
            oy = $urandom();
            oz = $urandom();
            ax = rand_axis();
            ay = rand_axis();
            az = rand_axis();
            st = (ph % 3 == 0) ? $urandom() : small_offset($urandom_range(24, 8));
            rt = $urandom();
            case (ph)
                0: begin ax = 16384; ay = 0; az = 0; rt = 16384; end
                1: begin ax = 0; ay = 32'hffff_c000; az = 0; st = 32'h7fff_ffff; end
                2: begin ax = 11585; ay = 0; az = 32'hffff_d2bf; st = 32'h8000_0000; end
                3: begin ox = 0; oy = 0; oz = 0; rt = {16'sd16384, 16'sd0}; end
                4: begin ax = 32'hffff_c000; ay = 32'hffff_c000; az = 32'hffff_c000; end
                default: ;
            endcase
            write_all(ox, oy, oz, ax, ay, az, st, rt);
            for (int n = 0; n < 200; n++) begin
                sel = $urandom_range(99);
                for (int i = 0; i < 3; i++) begin
                    k = $urandom_range(20);
                    if (sel < 25) p[i] = $urandom();
                    else if (sel < 40) p[i] = ((i == 0) ? ox : (i == 1) ? oy : oz)
                                              + small_offset($urandom_range(3));
                    else p[i] = ((i == 0) ? ox : (i == 1) ? oy : oz) + small_offset(k);
                    vin[i] = ($urandom_range(9) == 0)
                             ? {$urandom_range(1) ? 1'b1 : 1'b0, {31{$urandom_range(1) == 1}}}
                             : $urandom();
                end
                send_particle(p[0], p[1], p[2], vin[0], vin[1], vin[2]);
                if (ph == 5 && n == 100) begin
                    stop_sending();
                    while (pending_vel.size() != 0) @(posedge i_clk);
                end
                idle_gap();
            end
            stop_sending();
        end
    endtask

    // result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_vel_beat exp_v;
        logic [31:0] got[3];
        if (i_rst_n && o_valid) begin
            got = '{o_new_vel_x, o_new_vel_y, o_new_vel_z};
            if (pending_vel.size() == 0) begin
                $display("%0t: result beat expected none actual x=%h y=%h z=%h on_axis=%b",
                         $time, o_new_vel_x, o_new_vel_y, o_new_vel_z, o_on_axis);
                fails++;
            end else begin
                exp_v = pending_vel.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got[i] !== exp_v.nv[i]) begin
                        $display("%0t: new_vel[%0d] expected %h actual %h", $time, i,
                                 exp_v.nv[i], got[i]);
                        fails++;
                    end
                if (o_on_axis !== exp_v.on_axis) begin
                    $display("%0t: on_axis expected %b actual %b", $time,
                             exp_v.on_axis, o_on_axis);
                    fails++;
                end
            end
        end
    end

    // watchdog: cycles with neither an accepted input nor a result beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("cylindrical_vortex_velocity_update: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_phases();
        while (pending_vel.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (fails == 0) begin
            $display("cylindrical_vortex_velocity_update: match");
        end else begin
            $display("cylindrical_vortex_velocity_update: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> cylindrical_vortex_velocity_update.f
rtl/core/cvv_pkg.sv
rtl/core/cvv_isqrt.sv
rtl/core/cvv_div.sv
rtl/core/cylindrical_vortex_velocity_update.sv
verif/tb_cylindrical_vortex_velocity_update.sv
